@@ sv/rwm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rwm_pkg: shared types, constants and helpers of the rectilinear warp map
// Field widths, fixed-point formats, register codes, the register set type
// and the rounding and saturation helpers of the datapath.
// ----------------------------------------------------------------------------
package rwm_pkg;

    // port widths
    localparam int PIX_W      = 14;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int COEF_W     = 24;

    // fixed-point formats
    localparam int PIX_FRAC  = 8;
    localparam int INV_FRAC  = 31;
    localparam int NORM_FRAC = 24;

    // saturation limits as powers of two
    localparam int NORM_LIM_LG   = 25;
    localparam int FACTOR_LIM_LG = 31;
    localparam int OFFSET_LIM_LG = 34;
    localparam int OUT_LIM_LG    = 23;

    // parameter defaults
    localparam int MAX_DIM_DEF    = 16384;
    localparam int COEF_FRAC_DEF  = 20;

    // pipeline depth, input register to output register
    localparam int NSTG = 15;

    // reset value of the constant radial coefficient (1.0)
    localparam logic [COEF_W-1:0] K0_RESET = 24'h100000;

    // register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER     = 3'd0,
        CFG_RADIUS     = 3'd1,
        CFG_INV_RADIUS = 3'd2,
        CFG_K0         = 3'd3,
        CFG_K1         = 3'd4,
        CFG_K2         = 3'd5,
        CFG_K3         = 3'd6,
        CFG_TANGENT    = 3'd7
    } t_cfg_idx;

    // register set as seen by the datapath
    typedef struct packed {
        logic [21:0]              center_x;
        logic [21:0]              center_y;
        logic [22:0]              radius;
        logic [31:0]              inv_radius;
        logic signed [COEF_W-1:0] k0;
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] k3;
        logic signed [COEF_W-1:0] p1;
        logic signed [COEF_W-1:0] p2;
    } t_cfg;

    // round half up, then arithmetic shift right
    function automatic logic signed [63:0] rshr64(input logic signed [63:0] v,
                                                  input int sh);
        rshr64 = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // saturate to [-2^lg, 2^lg - 1]
    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input int lg);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< lg;
        if (v > lim - 64'sd1) begin
            clamp64 = lim - 64'sd1;
        end else if (v < -lim) begin
            clamp64 = -lim;
        end else begin
            clamp64 = v;
        end
    endfunction

    // true when clamp64 would saturate
    function automatic logic over64(input logic signed [63:0] v, input int lg);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< lg;
        over64 = (v > lim - 64'sd1) || (v < -lim);
    endfunction

endpackage
`default_nettype wire

@@ sv/rectilinear_warp_map.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rectilinear_warp_map: lens warp source coordinate generator
// Maps a destination pixel to its source coordinate under a radial plus
// tangential lens model, in signed Q16.8 with a saturation flag.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_in_valid / o_in_stall carry one pixel index pair per
//   item. Output channel: o_out_valid / i_out_stall carry source_x,
//   source_y and clipped. An item moves when valid is high and stall low.
//   Configuration: i_cfg_valid / o_cfg_ready write register i_cfg_index;
//   ready is always high. Write registers only while the pipeline is empty.
//   Throughput: one item per cycle unless the output is stalled; the
//   pipeline is 15 register stages, each holding a multiplier or a
//   rounding, adding and saturation step.
//   Stall: when the output item is stalled the whole pipeline holds and
//   o_in_stall goes high in the same cycle; nothing is dropped or repeated.
//   Reset: synchronous, active low; clears all valid bits and loads the
//   register reset values (identity map, k0 = 1.0).
//   Radius zero gives the identity map; clipped is then always low.
// ----------------------------------------------------------------------------
module rectilinear_warp_map #(
    parameter int MAX_DIM        = rwm_pkg::MAX_DIM_DEF,
    parameter int COEF_FRAC_BITS = rwm_pkg::COEF_FRAC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [rwm_pkg::PIX_W-1:0]          i_pixel_x,
    input  logic [rwm_pkg::PIX_W-1:0]          i_pixel_y,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [rwm_pkg::OUT_W-1:0]   o_source_x,
    output logic signed [rwm_pkg::OUT_W-1:0]   o_source_y,
    output logic                               o_clipped,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rwm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rwm_pkg::*;

    localparam logic [31:0] PIX_LIM   = 32'(MAX_DIM - 1);
    localparam int          TW        = 54 - COEF_FRAC_BITS;
    localparam int          INV_SHIFT = PIX_FRAC + INV_FRAC - NORM_FRAC;
    localparam int          PAD_W     = OUT_W - PIX_W - PIX_FRAC;

    t_cfg             cfg;
    logic             en;
    logic [NSTG-1:0]  r_vld;

    // stage registers
    logic signed [22:0]     r_ddx_s1, r_ddy_s1;
    logic signed [55:0]     r_mx_s2, r_my_s2;
    logic signed [51:0]     r_sxx_s4, r_syy_s4, r_sxy_s4;
    logic signed [28:0]     r_r2_s5, r_txy_s5;
    logic signed [29:0]     r_ax_s5, r_ay_s5;
    logic signed [57:0]     r_r2sq_s6;
    logic signed [52:0]     r_k1r2_s6, r_txa_s6, r_tya_s6;
    logic signed [53:0]     r_txb_s6, r_tyb_s6;
    logic signed [28:0]     r_r2_s6, r_r2_s7;
    logic signed [31:0]     r_r4_s7;
    logic signed [52:0]     r_k1r2_s7, r_k1r2_s8;
    logic signed [60:0]     r_r4r2_s8;
    logic signed [55:0]     r_k2r4_s8;
    logic signed [34:0]     r_r6_s9;
    logic signed [55:0]     r_ksum_s9, r_ksum_s10;
    logic signed [58:0]     r_k3r6_s10;
    logic signed [31:0]     r_f_s11;
    logic signed [57:0]     r_fdx_s12, r_fdy_s12;
    logic signed [34:0]     r_ux_s13, r_uy_s13;
    logic signed [58:0]     r_uxm_s14, r_uym_s14;
    logic signed [OUT_W-1:0] r_out_x, r_out_y;
    logic                    r_out_clip;

    // shift lines for values carried across stages
    logic [PIX_W-1:0]    r_ixp [1:NSTG-1];
    logic [PIX_W-1:0]    r_iyp [1:NSTG-1];
    logic signed [25:0]  r_dxp [3:11];
    logic signed [25:0]  r_dyp [3:11];
    logic signed [TW-1:0] r_txp [7:12];
    logic signed [TW-1:0] r_typ [7:12];
    logic                r_clp [3:14];

    // next values
    logic [PIX_W-1:0]        n_ix, n_iy;
    logic signed [22:0]      n_ddx, n_ddy;
    logic signed [25:0]      n_dx, n_dy;
    logic                    n_dclip;
    logic signed [28:0]      n_r2, n_txy;
    logic signed [29:0]      n_ax, n_ay;
    logic signed [31:0]      n_r4;
    logic signed [TW-1:0]    n_tx, n_ty;
    logic signed [34:0]      n_r6;
    logic signed [55:0]      n_ksum;
    logic signed [31:0]      n_f;
    logic                    n_fclip;
    logic signed [34:0]      n_ux, n_uy;
    logic                    n_uclip;
    logic signed [OUT_W-1:0] n_out_x, n_out_y;
    logic                    n_out_clip;

    // configuration registers
    rwm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_cfg_ready = 1'b1;

    // pipeline advances unless the output item is held
    assign en          = ~r_vld[NSTG-1] | ~i_out_stall;
    assign o_in_stall  = ~en;
    assign o_out_valid = r_vld[NSTG-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // rounding, saturation and adds between the multipliers
    always_comb begin
        logic signed [63:0] t_x, t_y, t_f, t_ux, t_uy, t_ox, t_oy;

        // index saturation and offset from center
        n_ix  = (32'(i_pixel_x) > PIX_LIM) ? PIX_LIM[PIX_W-1:0] : i_pixel_x;
        n_iy  = (32'(i_pixel_y) > PIX_LIM) ? PIX_LIM[PIX_W-1:0] : i_pixel_y;
        n_ddx = $signed({1'b0, n_ix, {PIX_FRAC{1'b0}}}) - $signed({1'b0, cfg.center_x});
        n_ddy = $signed({1'b0, n_iy, {PIX_FRAC{1'b0}}}) - $signed({1'b0, cfg.center_y});

        // normalized offset, saturated to +-2.0
        t_x     = rshr64(64'(r_mx_s2), INV_SHIFT);
        t_y     = rshr64(64'(r_my_s2), INV_SHIFT);
        n_dx    = 26'(clamp64(t_x, NORM_LIM_LG));
        n_dy    = 26'(clamp64(t_y, NORM_LIM_LG));
        n_dclip = over64(t_x, NORM_LIM_LG) | over64(t_y, NORM_LIM_LG);

        // r squared, 2xy and r2 + 2d^2
        n_r2  = 29'(rshr64(64'(r_sxx_s4) + 64'(r_syy_s4), NORM_FRAC));
        n_txy = 29'(rshr64(64'(r_sxy_s4), NORM_FRAC - 1));
        n_ax  = 30'(64'(n_r2) + rshr64(64'(r_sxx_s4), NORM_FRAC - 1));
        n_ay  = 30'(64'(n_r2) + rshr64(64'(r_syy_s4), NORM_FRAC - 1));

        // r4 and the tangential terms
        n_r4 = 32'(rshr64(64'(r_r2sq_s6), NORM_FRAC));
        n_tx = TW'(rshr64(64'(r_txa_s6) + 64'(r_txb_s6), COEF_FRAC_BITS));
        n_ty = TW'(rshr64(64'(r_tya_s6) + 64'(r_tyb_s6), COEF_FRAC_BITS));

        // r6 and the partial polynomial sum
        n_r6   = 35'(rshr64(64'(r_r4r2_s8), NORM_FRAC));
        n_ksum = 56'((64'($signed(cfg.k0)) <<< NORM_FRAC) + 64'(r_k1r2_s8)
                     + 64'(r_k2r4_s8));

        // radial factor, saturated to +-128.0
        t_f     = rshr64(64'(r_ksum_s10) + 64'(r_k3r6_s10), COEF_FRAC_BITS);
        n_f     = 32'(clamp64(t_f, FACTOR_LIM_LG));
        n_fclip = over64(t_f, FACTOR_LIM_LG);

        // pre-scale offset, saturated to +-1024.0
        t_ux    = rshr64(64'(r_fdx_s12), NORM_FRAC) + 64'(r_txp[12]);
        t_uy    = rshr64(64'(r_fdy_s12), NORM_FRAC) + 64'(r_typ[12]);
        n_ux    = 35'(clamp64(t_ux, OFFSET_LIM_LG));
        n_uy    = 35'(clamp64(t_uy, OFFSET_LIM_LG));
        n_uclip = over64(t_ux, OFFSET_LIM_LG) | over64(t_uy, OFFSET_LIM_LG);

        // back to pixels around the center, or identity
        t_ox = 64'($signed({1'b0, cfg.center_x})) + rshr64(64'(r_uxm_s14), NORM_FRAC);
        t_oy = 64'($signed({1'b0, cfg.center_y})) + rshr64(64'(r_uym_s14), NORM_FRAC);
        if (cfg.radius == '0) begin
            // a 14-bit index in Q.8 always fits the output range
            n_out_x    = $signed({{PAD_W{1'b0}}, r_ixp[NSTG-1], {PIX_FRAC{1'b0}}});
            n_out_y    = $signed({{PAD_W{1'b0}}, r_iyp[NSTG-1], {PIX_FRAC{1'b0}}});
            n_out_clip = 1'b0;
        end else begin
            n_out_x    = OUT_W'(clamp64(t_ox, OUT_LIM_LG));
            n_out_y    = OUT_W'(clamp64(t_oy, OUT_LIM_LG));
            n_out_clip = r_clp[14] | over64(t_ox, OUT_LIM_LG) | over64(t_oy, OUT_LIM_LG);
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: offset from center
            r_ddx_s1 <= n_ddx;
            r_ddy_s1 <= n_ddy;
            // stage 2: scale by reciprocal radius
            r_mx_s2  <= r_ddx_s1 * $signed({1'b0, cfg.inv_radius});
            r_my_s2  <= r_ddy_s1 * $signed({1'b0, cfg.inv_radius});
            // stage 3: normalized offset
            r_dxp[3] <= n_dx;
            r_dyp[3] <= n_dy;
            r_clp[3] <= n_dclip;
            // stage 4: squares and cross product
            r_sxx_s4 <= r_dxp[3] * r_dxp[3];
            r_syy_s4 <= r_dyp[3] * r_dyp[3];
            r_sxy_s4 <= r_dxp[3] * r_dyp[3];
            // stage 5: r2 and tangential inputs
            r_r2_s5  <= n_r2;
            r_txy_s5 <= n_txy;
            r_ax_s5  <= n_ax;
            r_ay_s5  <= n_ay;
            // stage 6: r2 squared, k1 term, tangential products
            r_r2sq_s6 <= r_r2_s5 * r_r2_s5;
            r_k1r2_s6 <= $signed(cfg.k1) * r_r2_s5;
            r_txa_s6  <= $signed(cfg.p1) * r_txy_s5;
            r_txb_s6  <= $signed(cfg.p2) * r_ax_s5;
            r_tya_s6  <= $signed(cfg.p2) * r_txy_s5;
            r_tyb_s6  <= $signed(cfg.p1) * r_ay_s5;
            r_r2_s6   <= r_r2_s5;
            // stage 7: r4 and tangential sums
            r_r4_s7   <= n_r4;
            r_r2_s7   <= r_r2_s6;
            r_k1r2_s7 <= r_k1r2_s6;
            r_txp[7]  <= n_tx;
            r_typ[7]  <= n_ty;
            // stage 8: r4 times r2, k2 term
            r_r4r2_s8 <= r_r4_s7 * r_r2_s7;
            r_k2r4_s8 <= $signed(cfg.k2) * r_r4_s7;
            r_k1r2_s8 <= r_k1r2_s7;
            // stage 9: r6 and partial sum
            r_r6_s9   <= n_r6;
            r_ksum_s9 <= n_ksum;
            // stage 10: k3 term
            r_k3r6_s10 <= $signed(cfg.k3) * r_r6_s9;
            r_ksum_s10 <= r_ksum_s9;
            // stage 11: radial factor
            r_f_s11   <= n_f;
            r_clp[11] <= r_clp[10] | n_fclip;
            // stage 12: radial scaling of the offset
            r_fdx_s12 <= r_f_s11 * r_dxp[11];
            r_fdy_s12 <= r_f_s11 * r_dyp[11];
            r_clp[12] <= r_clp[11];
            // stage 13: pre-scale offset
            r_ux_s13  <= n_ux;
            r_uy_s13  <= n_uy;
            r_clp[13] <= r_clp[12] | n_uclip;
            // stage 14: scale by radius
            r_uxm_s14 <= r_ux_s13 * $signed({1'b0, cfg.radius});
            r_uym_s14 <= r_uy_s13 * $signed({1'b0, cfg.radius});
            r_clp[14] <= r_clp[13];
            // stage 15: output register
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_clip <= n_out_clip;

            // carried values
            r_ixp[1] <= n_ix;
            r_iyp[1] <= n_iy;
            for (int k = 2; k <= NSTG - 1; k++) begin
                r_ixp[k] <= r_ixp[k-1];
                r_iyp[k] <= r_iyp[k-1];
            end
            for (int k = 4; k <= 11; k++) begin
                r_dxp[k] <= r_dxp[k-1];
                r_dyp[k] <= r_dyp[k-1];
            end
            for (int k = 4; k <= 10; k++) begin
                r_clp[k] <= r_clp[k-1];
            end
            for (int k = 8; k <= 12; k++) begin
                r_txp[k] <= r_txp[k-1];
                r_typ[k] <= r_typ[k-1];
            end
        end
    end

    assign o_source_x = r_out_x;
    assign o_source_y = r_out_y;
    assign o_clipped  = r_out_clip;

endmodule
`default_nettype wire

@@ sv/rwm_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rwm_cfg_regs: configuration registers of the rectilinear warp map
// Decodes register writes and holds the lens model parameters.
// ----------------------------------------------------------------------------
module rwm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [rwm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rwm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rwm_pkg::t_cfg                    o_cfg
);
    import rwm_pkg::*;

    t_cfg r_cfg;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg            <= '0;
            r_cfg.k0         <= K0_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER: begin
                    r_cfg.center_x <= i_cfg_data[21:0];
                    r_cfg.center_y <= i_cfg_data[43:22];
                end
                CFG_RADIUS:     r_cfg.radius     <= i_cfg_data[22:0];
                CFG_INV_RADIUS: r_cfg.inv_radius <= i_cfg_data[31:0];
                CFG_K0:         r_cfg.k0         <= i_cfg_data[COEF_W-1:0];
                CFG_K1:         r_cfg.k1         <= i_cfg_data[COEF_W-1:0];
                CFG_K2:         r_cfg.k2         <= i_cfg_data[COEF_W-1:0];
                CFG_K3:         r_cfg.k3         <= i_cfg_data[COEF_W-1:0];
                CFG_TANGENT: begin
                    r_cfg.p1 <= i_cfg_data[COEF_W-1:0];
                    r_cfg.p2 <= i_cfg_data[2*COEF_W-1:COEF_W];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ sv/rwm_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rwm_checker: port-level checks of the rectilinear warp map
// Watches the handshakes on the top level ports and is bound to it.
// ----------------------------------------------------------------------------
module rwm_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             o_in_stall,
    input  wire                             o_out_valid,
    input  wire                             i_out_stall,
    input  wire signed [rwm_pkg::OUT_W-1:0] o_source_x,
    input  wire signed [rwm_pkg::OUT_W-1:0] o_source_y,
    input  wire                             o_clipped,
    input  wire                             o_cfg_ready
);

    // input side holds exactly when the output item is held
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output backpressure");

    // a held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_source_x)
            && $stable(o_source_y) && $stable(o_clipped)))
        else $error("held result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // register port never refuses a write once out of reset
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind rectilinear_warp_map rwm_checker u_rwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_source_x  (o_source_x),
    .o_source_y  (o_source_y),
    .o_clipped   (o_clipped),
    .o_cfg_ready (o_cfg_ready)
);
`default_nettype wire
